>>> hdl/stkuw_pkg.sv
// Shared types and constants for the unwindable stack.
package stkuw_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int DATA_W      = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int OUT_CNT_W   = 5;

    // Reported for top and popped value when there is nothing to report.
    localparam logic signed [DATA_W-1:0] EMPTY_MARK = -32'sd1000;

    typedef enum logic [1:0] {
        CMD_PUSH   = 2'd0,
        CMD_POP    = 2'd1,
        CMD_UNWIND = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic {
        ST_IDLE,
        ST_UNWIND
    } t_state;

    // Shift control broadcast to every cell of the chain.
    typedef struct packed {
        logic push;
        logic pop;
    } t_shift;

endpackage

>>> hdl/stkuw_cell.sv
// One stack cell: takes its upper neighbour's word on push, its lower one's on pop.
module stkuw_cell (
    input  logic                                    i_clk,
    input  stkuw_pkg::t_shift                       i_shift,
    input  logic signed [stkuw_pkg::DATA_W-1:0]     i_above,
    input  logic signed [stkuw_pkg::DATA_W-1:0]     i_below,
    output logic signed [stkuw_pkg::DATA_W-1:0]     o_value
);

    logic signed [stkuw_pkg::DATA_W-1:0] r_value;

    always_ff @(posedge i_clk) begin
        if (i_shift.push) begin
            r_value <= i_above;
        end else if (i_shift.pop) begin
            r_value <= i_below;
        end
    end

    assign o_value = r_value;

endmodule

>>> hdl/stack_with_unwind_to_value_core.sv
// Top level: LIFO stack built as a shifting chain of cells, with unwind-to-value.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+--------------------------------------------
//  in      | into      | i_in_valid / o_in_ready | i_command, i_data_value
//  out     | out of    | o_out_valid / i_out_ready | o_popped_value, o_top_value,
//          |           |                         | o_entry_count, o_match_found, o_overflow
//
// Push, pop and clear: the result is registered at the accepting edge.
// Unwind: the item is taken and its key stored, then the top entry is removed while
// it differs from the key, and the result is loaded once the stack is empty or the top
// matches; the top cell is compared once per cycle while the chain shifts up.
// Reset clears the count and the control state; cell contents are not reset.
// A held output item stalls the input and the end of an unwind until it is taken.
module stack_with_unwind_to_value_core (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [1:0]                              i_command,
    input  logic signed [stkuw_pkg::DATA_W-1:0]     i_data_value,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [stkuw_pkg::DATA_W-1:0]     o_popped_value,
    output logic signed [stkuw_pkg::DATA_W-1:0]     o_top_value,
    output logic [stkuw_pkg::OUT_CNT_W-1:0]         o_entry_count,
    output logic                                    o_match_found,
    output logic                                    o_overflow
);

    localparam int LAST = stkuw_pkg::STACK_DEPTH - 1;

    stkuw_pkg::t_state                      r_state, n_state;
    logic [stkuw_pkg::CNT_W-1:0]            r_count, n_count;
    logic signed [stkuw_pkg::DATA_W-1:0]    r_key, n_key;
    logic                                   r_out_valid;
    logic signed [stkuw_pkg::DATA_W-1:0]    r_popped, n_popped;
    logic signed [stkuw_pkg::DATA_W-1:0]    r_top, n_top;
    logic [stkuw_pkg::OUT_CNT_W-1:0]        r_entry_count;
    logic                                   r_found, n_found;
    logic                                   r_ovf, n_ovf;

    stkuw_pkg::t_shift                      w_shift;
    stkuw_pkg::t_cmd                        w_cmd;
    logic                                   w_out_free;
    logic                                   w_accept;
    logic                                   w_empty;
    logic                                   w_unwind_done;
    logic                                   w_out_load;
    logic signed [stkuw_pkg::DATA_W-1:0]    w_cell  [stkuw_pkg::STACK_DEPTH];

    // Cell 0 is the top of stack.
    for (genvar gi = 0; gi < stkuw_pkg::STACK_DEPTH; gi++) begin : g_cell
        logic signed [stkuw_pkg::DATA_W-1:0] w_above;
        logic signed [stkuw_pkg::DATA_W-1:0] w_below;

        if (gi == 0) begin : g_top
            assign w_above = i_data_value;
        end else begin : g_mid
            assign w_above = w_cell[gi-1];
        end

        if (gi == LAST) begin : g_bot
            assign w_below = w_cell[gi];
        end else begin : g_nbot
            assign w_below = w_cell[gi+1];
        end

        stkuw_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_above (w_above),
            .i_below (w_below),
            .o_value (w_cell[gi])
        );
    end

    assign w_cmd         = stkuw_pkg::t_cmd'(i_command);
    assign w_out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready    = (r_state == stkuw_pkg::ST_IDLE) && w_out_free;
    assign w_accept      = i_in_valid && o_in_ready;
    assign w_empty       = (r_count == '0);
    assign w_unwind_done = w_empty || (w_cell[0] == r_key);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stkuw_pkg::ST_IDLE: begin
                if (w_accept && (w_cmd == stkuw_pkg::CMD_UNWIND)) begin
                    n_state = stkuw_pkg::ST_UNWIND;
                end
            end
            stkuw_pkg::ST_UNWIND: begin
                if (w_unwind_done && w_out_free) begin
                    n_state = stkuw_pkg::ST_IDLE;
                end
            end
            default: n_state = stkuw_pkg::ST_IDLE;
        endcase
    end

    // Datapath control and result
    always_comb begin
        w_shift    = '0;
        w_out_load = 1'b0;
        n_count    = r_count;
        n_key      = r_key;
        n_popped   = '0;
        n_top      = stkuw_pkg::EMPTY_MARK;
        n_found    = 1'b0;
        n_ovf      = 1'b0;
        unique case (r_state)
            stkuw_pkg::ST_IDLE: begin
                if (w_accept) begin
                    unique case (w_cmd)
                        stkuw_pkg::CMD_PUSH: begin
                            w_out_load = 1'b1;
                            if (r_count == stkuw_pkg::CNT_W'(stkuw_pkg::STACK_DEPTH)) begin
                                n_ovf = 1'b1;
                                n_top = w_cell[0];
                            end else begin
                                w_shift.push = 1'b1;
                                n_count      = r_count + 1'b1;
                                n_top        = i_data_value;
                            end
                        end
                        stkuw_pkg::CMD_POP: begin
                            w_out_load = 1'b1;
                            if (w_empty) begin
                                n_popped = stkuw_pkg::EMPTY_MARK;
                            end else begin
                                w_shift.pop = 1'b1;
                                n_count     = r_count - 1'b1;
                                n_popped    = w_cell[0];
                                if (r_count != stkuw_pkg::CNT_W'(1)) begin
                                    n_top = w_cell[1];
                                end
                            end
                        end
                        stkuw_pkg::CMD_UNWIND: begin
                            n_key = i_data_value;
                        end
                        stkuw_pkg::CMD_CLEAR: begin
                            w_out_load = 1'b1;
                            n_count    = '0;
                        end
                        default: ;
                    endcase
                end
            end
            stkuw_pkg::ST_UNWIND: begin
                if (w_unwind_done) begin
                    if (w_out_free) begin
                        w_out_load = 1'b1;
                        n_found    = !w_empty;
                        if (!w_empty) begin
                            n_top = w_cell[0];
                        end
                    end
                end else begin
                    w_shift.pop = 1'b1;
                    n_count     = r_count - 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= stkuw_pkg::ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        if (w_out_load) begin
            r_popped      <= n_popped;
            r_top         <= n_top;
            r_entry_count <= stkuw_pkg::OUT_CNT_W'(n_count);
            r_found       <= n_found;
            r_ovf         <= n_ovf;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_popped_value = r_popped;
    assign o_top_value    = r_top;
    assign o_entry_count  = r_entry_count;
    assign o_match_found  = r_found;
    assign o_overflow     = r_ovf;

endmodule

>>> tb/sv/tb_stack_with_unwind_to_value_core.sv
// Self-checking testbench for the unwindable stack core: directed table, then random traffic.
module tb_stack_with_unwind_to_value_core;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 160;
    localparam int MAX_GAP        = 40;

    typedef struct packed {
        logic signed [stkuw_pkg::DATA_W-1:0] popped;
        logic signed [stkuw_pkg::DATA_W-1:0] top;
        logic [stkuw_pkg::OUT_CNT_W-1:0]     cnt;
        logic                                found;
        logic                                ovf;
    } t_result;

    // One directed row; pushes with reps > 1 use val, val+1, ...
    typedef struct packed {
        stkuw_pkg::t_cmd                     cmd;
        logic signed [stkuw_pkg::DATA_W-1:0] val;
        logic [4:0]                          reps;
        logic                                typed;
        t_result                             res;
    } t_row;

    localparam logic signed [stkuw_pkg::DATA_W-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [stkuw_pkg::DATA_W-1:0] VMIN = 32'sh8000_0000;
    localparam logic signed [stkuw_pkg::DATA_W-1:0] MARK = stkuw_pkg::EMPTY_MARK;

    logic                                i_clk          = 1'b0;
    logic                                i_rst_n        = 1'b0;
    logic                                i_in_valid     = 1'b0;
    logic [1:0]                          i_command      = stkuw_pkg::CMD_PUSH;
    logic signed [stkuw_pkg::DATA_W-1:0] i_data_value   = '0;
    logic                                i_out_ready    = 1'b0;
    logic                                o_in_ready;
    logic                                o_out_valid;
    logic signed [stkuw_pkg::DATA_W-1:0] o_popped_value;
    logic signed [stkuw_pkg::DATA_W-1:0] o_top_value;
    logic [stkuw_pkg::OUT_CNT_W-1:0]     o_entry_count;
    logic                                o_match_found;
    logic                                o_overflow;

    // Predicted stack contents
    logic signed [stkuw_pkg::DATA_W-1:0] stk_mem [stkuw_pkg::STACK_DEPTH];
    int                                  stk_cnt = 0;

    t_result stack_results[$];
    t_row    dir_tab [25];

    int send_idle_pct = 35;
    int recv_idle_pct = 84;
    int errors        = 0;
    int n_sent        = 0;
    int n_checked     = 0;
    int n_ovf         = 0;
    int n_found       = 0;
    int idle_cycles   = 0;

    stack_with_unwind_to_value_core u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_data_value   (i_data_value),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_popped_value (o_popped_value),
        .o_top_value    (o_top_value),
        .o_entry_count  (o_entry_count),
        .o_match_found  (o_match_found),
        .o_overflow     (o_overflow)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_result stack_step(stkuw_pkg::t_cmd cmd,
                                           logic signed [stkuw_pkg::DATA_W-1:0] val);
        t_result r;
        r = '0;
        case (cmd)
            stkuw_pkg::CMD_PUSH: begin
                if (stk_cnt >= stkuw_pkg::STACK_DEPTH) begin
                    r.ovf = 1'b1;
                end else begin
                    stk_mem[stk_cnt] = val;
                    stk_cnt++;
                end
            end
            stkuw_pkg::CMD_POP: begin
                if (stk_cnt == 0) begin
                    r.popped = stkuw_pkg::EMPTY_MARK;
                end else begin
                    stk_cnt--;
                    r.popped = stk_mem[stk_cnt];
                end
            end
            stkuw_pkg::CMD_UNWIND: begin
                while (stk_cnt > 0 && stk_mem[stk_cnt-1] != val)
                    stk_cnt--;
                r.found = (stk_cnt > 0);
            end
            default: stk_cnt = 0;
        endcase
        if (stk_cnt == 0)
            r.top = stkuw_pkg::EMPTY_MARK;
        else
            r.top = stk_mem[stk_cnt-1];
        r.cnt = stkuw_pkg::OUT_CNT_W'(stk_cnt);
        return r;
    endfunction

    task automatic send_item(input stkuw_pkg::t_cmd cmd,
                             input logic signed [stkuw_pkg::DATA_W-1:0] val,
                             input bit typed, input t_result typed_res);
        int      gap;
        t_result pred;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < MAX_GAP)
            gap++;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_command    <= cmd;
        i_data_value <= val;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        pred = stack_step(cmd, val);
        stack_results.push_back(typed ? typed_res : pred);
        n_sent++;
    endtask

    // Hold the input off until every outstanding result has been taken.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do
            @(posedge i_clk);
        while (stack_results.size() != 0);
    endtask

    task automatic run_random(input int n_items);
        stkuw_pkg::t_cmd                     cmd;
        logic signed [stkuw_pkg::DATA_W-1:0] val;
        int                                  r;
        for (int i = 0; i < n_items; i++) begin
            r = $urandom_range(99);
            if (r < 50)
                cmd = stkuw_pkg::CMD_PUSH;
            else if (r < 70)
                cmd = stkuw_pkg::CMD_POP;
            else if (r < 95)
                cmd = stkuw_pkg::CMD_UNWIND;
            else
                cmd = stkuw_pkg::CMD_CLEAR;
            // mostly small values so that unwinds find something
            r = $urandom_range(9);
            if (r < 5)
                val = $urandom_range(15);
            else if (r < 8)
                val = $urandom;
            else if (r < 9)
                val = -$urandom_range(15);
            else begin
                case ($urandom_range(3))
                    0:       val = VMAX;
                    1:       val = VMIN;
                    2:       val = MARK;
                    default: val = '0;
                endcase
            end
            // unwind targets mostly taken from the live contents
            if (cmd == stkuw_pkg::CMD_UNWIND && stk_cnt > 0 && $urandom_range(9) < 7)
                val = stk_mem[$urandom_range(stk_cnt - 1)];
            send_item(cmd, val, 1'b0, '0);
        end
    endtask

    task automatic field_mismatch(input string name,
                                  input logic signed [stkuw_pkg::DATA_W-1:0] want,
                                  input logic signed [stkuw_pkg::DATA_W-1:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    endtask

    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (stack_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, expected none, got top %0d count %0d",
                         $time, o_top_value, o_entry_count);
            end else begin
                want = stack_results.pop_front();
                n_checked++;
                if (o_overflow)
                    n_ovf++;
                if (o_match_found)
                    n_found++;
                if (o_popped_value !== want.popped)
                    field_mismatch("popped_value", want.popped, o_popped_value);
                if (o_top_value !== want.top)
                    field_mismatch("top_value", want.top, o_top_value);
                if (o_entry_count !== want.cnt)
                    field_mismatch("entry_count", want.cnt, o_entry_count);
                if (o_match_found !== want.found)
                    field_mismatch("match_found", want.found, o_match_found);
                if (o_overflow !== want.ovf)
                    field_mismatch("overflow", want.ovf, o_overflow);
            end
        end
    end

    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("tb_stack_with_unwind_to_value_core failed");
            $finish;
        end
    end

    initial begin
        dir_tab = '{
            '{stkuw_pkg::CMD_POP,    32'sd0,     5'd1,  1'b1,
              '{MARK, MARK, 5'd0, 1'b0, 1'b0}},
            '{stkuw_pkg::CMD_UNWIND, 32'sd5,     5'd1,  1'b1,
              '{32'sd0, MARK, 5'd0, 1'b0, 1'b0}},
            '{stkuw_pkg::CMD_CLEAR,  32'sd0,     5'd1,  1'b1,
              '{32'sd0, MARK, 5'd0, 1'b0, 1'b0}},
            '{stkuw_pkg::CMD_PUSH,   VMAX,       5'd1,  1'b1,
              '{32'sd0, VMAX, 5'd1, 1'b0, 1'b0}},
            '{stkuw_pkg::CMD_PUSH,   VMIN,       5'd1,  1'b1,
              '{32'sd0, VMIN, 5'd2, 1'b0, 1'b0}},
            // a stored -1000 looks like the empty marker
            '{stkuw_pkg::CMD_PUSH,   MARK,       5'd1,  1'b1,
              '{32'sd0, MARK, 5'd3, 1'b0, 1'b0}},
            '{stkuw_pkg::CMD_POP,    32'sd0,     5'd1,  1'b1,
              '{MARK, VMIN, 5'd2, 1'b0, 1'b0}},
            '{stkuw_pkg::CMD_PUSH,   32'sd100,   5'd14, 1'b0, '0},
            '{stkuw_pkg::CMD_PUSH,   32'sd7,     5'd1,  1'b1,
              '{32'sd0, 32'sd113, 5'd16, 1'b0, 1'b1}},
            '{stkuw_pkg::CMD_UNWIND, 32'sd113,   5'd1,  1'b1,
              '{32'sd0, 32'sd113, 5'd16, 1'b1, 1'b0}},
            '{stkuw_pkg::CMD_UNWIND, 32'sd103,   5'd1,  1'b1,
              '{32'sd0, 32'sd103, 5'd6, 1'b1, 1'b0}},
            '{stkuw_pkg::CMD_UNWIND, VMAX,       5'd1,  1'b1,
              '{32'sd0, VMAX, 5'd1, 1'b1, 1'b0}},
            '{stkuw_pkg::CMD_UNWIND, 32'sd12345, 5'd1,  1'b1,
              '{32'sd0, MARK, 5'd0, 1'b0, 1'b0}},
            '{stkuw_pkg::CMD_PUSH,   -32'sd1,    5'd16, 1'b0, '0},
            // full scan with no match
            '{stkuw_pkg::CMD_UNWIND, 32'sd999,   5'd1,  1'b1,
              '{32'sd0, MARK, 5'd0, 1'b0, 1'b0}},
            '{stkuw_pkg::CMD_PUSH,   32'sd42,    5'd16, 1'b0, '0},
            '{stkuw_pkg::CMD_CLEAR,  32'sd0,     5'd1,  1'b1,
              '{32'sd0, MARK, 5'd0, 1'b0, 1'b0}},
            '{stkuw_pkg::CMD_PUSH,   32'sd5,     5'd3,  1'b0, '0},
            '{stkuw_pkg::CMD_POP,    32'sd0,     5'd1,  1'b1,
              '{32'sd7, 32'sd6, 5'd2, 1'b0, 1'b0}},
            '{stkuw_pkg::CMD_PUSH,   32'sd6,     5'd1,  1'b0, '0},
            '{stkuw_pkg::CMD_UNWIND, 32'sd6,     5'd1,  1'b1,
              '{32'sd0, 32'sd6, 5'd3, 1'b1, 1'b0}},
            '{stkuw_pkg::CMD_UNWIND, 32'sd5,     5'd1,  1'b1,
              '{32'sd0, 32'sd5, 5'd1, 1'b1, 1'b0}},
            '{stkuw_pkg::CMD_POP,    32'sd0,     5'd1,  1'b1,
              '{32'sd5, MARK, 5'd0, 1'b0, 1'b0}},
            '{stkuw_pkg::CMD_PUSH,   MARK,       5'd1,  1'b0, '0},
            '{stkuw_pkg::CMD_UNWIND, MARK,       5'd1,  1'b1,
              '{32'sd0, MARK, 5'd1, 1'b1, 1'b0}}
        };

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i])
            for (int k = 0; k < dir_tab[i].reps; k++)
                send_item(dir_tab[i].cmd, dir_tab[i].val + k, dir_tab[i].typed,
                          dir_tab[i].res);
        run_random(RANDOM_ITEMS);
        drain_results();

        send_idle_pct = 84;
        recv_idle_pct = 35;
        run_random(RANDOM_ITEMS);
        drain_results();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(RANDOM_ITEMS + 1);
        drain_results();

        // catch stray results after the last expected one
        repeat (stkuw_pkg::STACK_DEPTH + 8) @(posedge i_clk);

        $display("%0d items sent, %0d results checked under three idling mixes",
                 n_sent, n_checked);
        $display("%0d refused pushes, %0d unwinds ending on a match", n_ovf, n_found);
        if (errors == 0 && stack_results.size() == 0)
            $display("tb_stack_with_unwind_to_value_core passed");
        else
            $display("tb_stack_with_unwind_to_value_core failed");
        $finish;
    end

endmodule
